// ===== hw/rtl/ccp_pkg.sv =====
// Shared types, constants and the arctangent table for the CORDIC
// Cartesian-to-polar pipeline. No dependencies.
`default_nettype none

package ccp_pkg;

  localparam int DATA_W     = 16;
  localparam int ITERATIONS = 11;
  localparam int IDX_W      = $clog2(ITERATIONS);

  localparam logic signed [DATA_W-1:0] PI_Q13 = 16'sd25735;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
  } side_t;

  function automatic data_t atan_q13(input logic [IDX_W-1:0] idx);
    data_t res;
    case (idx)
      4'd0:    res = 16'sd6433;
      4'd1:    res = 16'sd3798;
      4'd2:    res = 16'sd2006;
      4'd3:    res = 16'sd1018;
      4'd4:    res = 16'sd511;
      4'd5:    res = 16'sd255;
      4'd6:    res = 16'sd127;
      4'd7:    res = 16'sd63;
      4'd8:    res = 16'sd31;
      4'd9:    res = 16'sd15;
      4'd10:   res = 16'sd7;
      default: res = 16'sd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cordic_cartesian_to_polar_top.sv =====
// CORDIC vectoring pipeline converting (x, y) Q3.13 to magnitude and angle.
// Stages: input stage, one stage per micro-rotation (11), output stage.
// Throughput is one request per cycle; a stall at the output freezes the whole pipeline.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
// Depends on ccp_pkg, ccp_prerot, ccp_stage and ccp_post.
`default_nettype none

module cordic_cartesian_to_polar_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [15:0]  in_x_coord,
  input  wire logic signed [15:0]  in_y_coord,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       out_magnitude,
  output logic signed [15:0]       out_angle
);

  logic           en;
  logic           s_valid [ccp_pkg::ITERATIONS+1];
  ccp_pkg::data_t s_x     [ccp_pkg::ITERATIONS+1];
  ccp_pkg::data_t s_y     [ccp_pkg::ITERATIONS+1];
  ccp_pkg::data_t s_th    [ccp_pkg::ITERATIONS+1];
  ccp_pkg::side_t s_side  [ccp_pkg::ITERATIONS+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign s_th[0] = '0;

  ccp_prerot u_prerot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .x_i     (in_x_coord),
    .y_i     (in_y_coord),
    .valid_o (s_valid[0]),
    .x_o     (s_x[0]),
    .y_o     (s_y[0]),
    .side_o  (s_side[0])
  );

  for (genvar i = 0; i < ccp_pkg::ITERATIONS; i++) begin : g_stage
    ccp_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .idx     (ccp_pkg::IDX_W'(i)),
      .valid_i (s_valid[i]),
      .x_i     (s_x[i]),
      .y_i     (s_y[i]),
      .th_i    (s_th[i]),
      .side_i  (s_side[i]),
      .valid_o (s_valid[i+1]),
      .x_o     (s_x[i+1]),
      .y_o     (s_y[i+1]),
      .th_o    (s_th[i+1]),
      .side_o  (s_side[i+1])
    );
  end

  ccp_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (s_valid[ccp_pkg::ITERATIONS]),
    .x_i     (s_x[ccp_pkg::ITERATIONS]),
    .th_i    (s_th[ccp_pkg::ITERATIONS]),
    .side_i  (s_side[ccp_pkg::ITERATIONS]),
    .valid_o (out_valid),
    .mag_o   (out_magnitude),
    .ang_o   (out_angle)
  );

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid set right after reset");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the pipeline enable");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s_valid[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && s_valid[ccp_pkg::ITERATIONS]) |=> s_valid[ccp_pkg::ITERATIONS])
    else $error("stalled request dropped from the last rotation stage");

endmodule

`default_nettype wire

// ===== hw/rtl/ccp_prerot.sv =====
// Input register stage with the 180 degree pre-rotation for negative x.
// Depends on ccp_pkg.
`default_nettype none

module ccp_prerot (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           valid_i,
  input  wire ccp_pkg::data_t x_i,
  input  wire ccp_pkg::data_t y_i,
  output logic                valid_o,
  output ccp_pkg::data_t      x_o,
  output ccp_pkg::data_t      y_o,
  output ccp_pkg::side_t      side_o
);

  logic           valid_r;
  ccp_pkg::data_t x_r, x_nxt;
  ccp_pkg::data_t y_r, y_nxt;
  ccp_pkg::side_t side_r, side_nxt;

  always_comb begin
    side_nxt.x_neg = x_i[ccp_pkg::DATA_W-1];
    side_nxt.y_neg = y_i[ccp_pkg::DATA_W-1];
    if (side_nxt.x_neg) begin
      x_nxt = -x_i;
      y_nxt = -y_i;
    end else begin
      x_nxt = x_i;
      y_nxt = y_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      side_r <= side_nxt;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign side_o  = side_r;

  // After the pre-rotation x is non-negative, except for the most negative value.
  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (!x_r[ccp_pkg::DATA_W-1] || x_r == 16'sh8000))
    else $error("pre-rotated x is negative");

endmodule

`default_nettype wire

// ===== hw/rtl/ccp_stage.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on ccp_pkg.
`default_nettype none

module ccp_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [ccp_pkg::IDX_W-1:0]     idx,
  input  wire logic                          valid_i,
  input  wire ccp_pkg::data_t                x_i,
  input  wire ccp_pkg::data_t                y_i,
  input  wire ccp_pkg::data_t                th_i,
  input  wire ccp_pkg::side_t                side_i,
  output logic                               valid_o,
  output ccp_pkg::data_t                     x_o,
  output ccp_pkg::data_t                     y_o,
  output ccp_pkg::data_t                     th_o,
  output ccp_pkg::side_t                     side_o
);

  logic           valid_r;
  ccp_pkg::data_t x_r, x_nxt;
  ccp_pkg::data_t y_r, y_nxt;
  ccp_pkg::data_t th_r, th_nxt;
  ccp_pkg::side_t side_r;
  ccp_pkg::data_t dx;
  ccp_pkg::data_t dy;
  ccp_pkg::data_t atan_val;

  always_comb begin
    dx       = y_i >>> idx;
    dy       = x_i >>> idx;
    atan_val = ccp_pkg::atan_q13(idx);
    if (!y_i[ccp_pkg::DATA_W-1]) begin
      x_nxt  = x_i + dx;
      y_nxt  = y_i - dy;
      th_nxt = th_i + atan_val;
    end else begin
      x_nxt  = x_i - dx;
      y_nxt  = y_i + dy;
      th_nxt = th_i - atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      th_r   <= th_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign th_o    = th_r;
  assign side_o  = side_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ccp_post.sv =====
// Output register stage: gain correction of the radius and quadrant fix of the angle.
// Depends on ccp_pkg.
`default_nettype none

module ccp_post (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           valid_i,
  input  wire ccp_pkg::data_t x_i,
  input  wire ccp_pkg::data_t th_i,
  input  wire ccp_pkg::side_t side_i,
  output logic                valid_o,
  output ccp_pkg::data_t      mag_o,
  output ccp_pkg::data_t      ang_o
);

  logic           valid_r;
  ccp_pkg::data_t mag_r, mag_nxt;
  ccp_pkg::data_t ang_r, ang_nxt;

  always_comb begin
    mag_nxt = (x_i >>> 1) + (x_i >>> 3) - (x_i >>> 6) - (x_i >>> 9);
    if (!side_i.x_neg) begin
      ang_nxt = th_i;
    end else if (!side_i.y_neg) begin
      ang_nxt = th_i + ccp_pkg::PI_Q13;
    end else begin
      ang_nxt = th_i - ccp_pkg::PI_Q13;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign valid_o = valid_r;
  assign mag_o   = mag_r;
  assign ang_o   = ang_r;

endmodule

`default_nettype wire

// ===== dv/cordic_polar_checker.sv =====
// Watches both channels of the CORDIC Cartesian-to-polar block, predicts the polar result
// of every accepted point and compares it with each accepted result in order.
// Depends on ccp_pkg for the data type, the iteration count and pi in Q3.13.
`default_nettype none

module cordic_polar_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  wire ccp_pkg::data_t in_x_coord,
  input  wire ccp_pkg::data_t in_y_coord,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  input  wire ccp_pkg::data_t out_magnitude,
  input  wire ccp_pkg::data_t out_angle,
  output int                  fail_count,
  output int                  outstanding
);

  typedef struct packed {
    ccp_pkg::data_t mag;
    ccp_pkg::data_t ang;
  } polar_t;

  localparam ccp_pkg::data_t ROT_ANGLE [0:10] = '{
    16'sd6433, 16'sd3798, 16'sd2006, 16'sd1018, 16'sd511, 16'sd255,
    16'sd127, 16'sd63, 16'sd31, 16'sd15, 16'sd7
  };

  polar_t polar_q[$];

  function automatic polar_t polar_of(input ccp_pkg::data_t x, input ccp_pkg::data_t y);
    ccp_pkg::data_t xc;
    ccp_pkg::data_t yc;
    ccp_pkg::data_t th;
    ccp_pkg::data_t dx;
    ccp_pkg::data_t dy;
    polar_t         res;
    th = '0;
    if (!x[ccp_pkg::DATA_W-1]) begin
      xc = x;
      yc = y;
    end else begin
      xc = -x;
      yc = -y;
    end
    for (int i = 0; i < ccp_pkg::ITERATIONS; i++) begin
      dx = yc >>> i;
      dy = xc >>> i;
      if (!yc[ccp_pkg::DATA_W-1]) begin
        xc = xc + dx;
        yc = yc - dy;
        th = th + ROT_ANGLE[i];
      end else begin
        xc = xc - dx;
        yc = yc + dy;
        th = th - ROT_ANGLE[i];
      end
    end
    res.mag = (xc >>> 1) + (xc >>> 3) - (xc >>> 6) - (xc >>> 9);
    if (!x[ccp_pkg::DATA_W-1]) begin
      res.ang = th;
    end else if (!y[ccp_pkg::DATA_W-1]) begin
      res.ang = ccp_pkg::PI_Q13 + th;
    end else begin
      res.ang = th - ccp_pkg::PI_Q13;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    polar_t want;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      polar_q.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready) begin
        polar_q.push_back(polar_of(in_x_coord, in_y_coord));
      end
      if (out_valid && out_ready) begin
        if (polar_q.size() == 0) begin
          $display("%0t: result (%0d, %0d) with no request pending", $time,
                   out_magnitude, out_angle);
          errs++;
        end else begin
          want = polar_q.pop_front();
          if (out_magnitude !== want.mag) begin
            $display("%0t: magnitude mismatch: expected %0d, actual %0d", $time,
                     want.mag, out_magnitude);
            errs++;
          end
          if (out_angle !== want.ang) begin
            $display("%0t: angle mismatch: expected %0d, actual %0d", $time,
                     want.ang, out_angle);
            errs++;
          end
        end
      end
      fail_count  <= fail_count + errs;
      outstanding <= polar_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_cordic_cartesian_to_polar_top.sv =====
// Top of the testbench for the CORDIC Cartesian-to-polar block: clock, reset, point
// stimulus with idle and stall phases, and the verdict. Depends on ccp_pkg, the block
// and cordic_polar_checker.
`default_nettype none

module tb_cordic_cartesian_to_polar_top;

  localparam int RANDOM_PER_PHASE = 475;
  localparam int HOLD_CYCLES      = 80;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  ccp_pkg::data_t in_x_coord = '0;
  ccp_pkg::data_t in_y_coord = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ccp_pkg::data_t out_magnitude;
  ccp_pkg::data_t out_angle;
  int             fail_count;
  int             outstanding;

  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_output = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cordic_cartesian_to_polar_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_magnitude (out_magnitude),
    .out_angle     (out_angle)
  );

  cordic_polar_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_magnitude (out_magnitude),
    .out_angle     (out_angle),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  task automatic send_point(input ccp_pkg::data_t x, input ccp_pkg::data_t y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic ccp_pkg::data_t pick_coord();
    ccp_pkg::data_t v;
    case ($urandom_range(3))
      0:       v = ccp_pkg::data_t'($urandom_range(65535));
      1:       v = ccp_pkg::data_t'(int'($urandom_range(16383)) - 8192);
      2:       v = ccp_pkg::data_t'(int'($urandom_range(24000)) - 12000);
      default: v = $urandom_range(1) ? 16'sh8000
                                     : ccp_pkg::data_t'(int'($urandom_range(511)) - 256);
    endcase
    return v;
  endfunction

  // The receiver either follows the stall rate of the phase or, on request, holds off
  // for a fixed stretch so the pipeline fills and backs up into the input.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    ccp_pkg::data_t dir_x [20] = '{16'sd0, 16'sd32767, 16'sd0, -16'sd32768, -16'sd32768,
                          -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, -16'sd1,
                          -16'sd1, -16'sd1, 16'sd0, 16'sd1, 16'sd8192,
                          -16'sd8192, -16'sd8192, 16'sd8192, -16'sd32768, 16'sd4096};
    ccp_pkg::data_t dir_y [20] = '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768,
                          16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd0,
                          -16'sd1, 16'sd1, -16'sd1, 16'sd0, 16'sd8192,
                          16'sd8192, -16'sd8192, -16'sd8192, 16'sd1, -16'sd4096};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_x[i]) send_point(dir_x[i], dir_y[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_output = 1'b1;
        end
        1: begin
          send_idle_pct = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_point(pick_coord(), pick_coord());
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== cordic_cartesian_to_polar_top.f =====
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_prerot.sv
hw/rtl/ccp_stage.sv
hw/rtl/ccp_post.sv
hw/rtl/cordic_cartesian_to_polar_top.sv
dv/cordic_polar_checker.sv
dv/tb_cordic_cartesian_to_polar_top.sv
